>>> rtl/core/kpdc_pkg.sv
// ----------------------------------------------------------------------------
// kpdc_pkg
// Shared types and constants for the key press duration classifier.
// ----------------------------------------------------------------------------
package kpdc_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] QUALIFY_RESET = 16'd5;
    localparam logic [CFG_W-1:0] ENTER_RESET   = 16'd100;
    localparam logic [CFG_W-1:0] EXIT_RESET    = 16'd200;
    localparam logic [CFG_W-1:0] HOLD_RESET    = 16'd300;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUALIFY = 2'd0,
        REG_ENTER   = 2'd1,
        REG_EXIT    = 2'd2,
        REG_HOLD    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PRESS = 2'd1,
        PH_HELD  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CL_IDLE  = 2'd0,
        CL_ENTER = 2'd1,
        CL_EXIT  = 2'd2,
        CL_EDIT  = 2'd3
    } class_t;

    typedef struct packed {
        logic [CFG_W-1:0] qualify_ticks;
        logic [CFG_W-1:0] enter_ticks;
        logic [CFG_W-1:0] exit_ticks;
        logic [CFG_W-1:0] hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic   key_event;
        class_t hold_class;
        phase_t key_phase;
    } result_t;

endpackage

>>> rtl/core/kpdc_in_if.sv
// ----------------------------------------------------------------------------
// kpdc_in_if
// Input item channel: one sampled key level per item.
// ----------------------------------------------------------------------------
interface kpdc_in_if;

    logic valid;
    logic ready;
    logic key_down;

    modport source (output valid, output key_down, input ready);
    modport sink   (input valid, input key_down, output ready);

endinterface

>>> rtl/core/kpdc_out_if.sv
// ----------------------------------------------------------------------------
// kpdc_out_if
// Result item channel: event flag, hold class and key phase.
// ----------------------------------------------------------------------------
interface kpdc_out_if;

    logic       valid;
    logic       ready;
    logic       key_event;
    logic [1:0] hold_class;
    logic [1:0] key_phase;

    modport source (output valid, output key_event, output hold_class, output key_phase,
                    input ready);
    modport sink   (input valid, input key_event, input hold_class, input key_phase,
                    output ready);

endinterface

>>> rtl/core/kpdc_cfg.sv
// ----------------------------------------------------------------------------
// kpdc_cfg
// Threshold register file with a plain indexed write port.
// ----------------------------------------------------------------------------
module kpdc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           we,
    input  logic [kpdc_pkg::CFG_IDX_W-1:0] idx,
    input  logic [kpdc_pkg::CFG_W-1:0]     data,
    output kpdc_pkg::cfg_t                 cfg
);
    import kpdc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (we)
        begin
            case (cfg_idx_t'(idx))
                REG_QUALIFY: cfg_next.qualify_ticks = data;
                REG_ENTER:   cfg_next.enter_ticks   = data;
                REG_EXIT:    cfg_next.exit_ticks    = data;
                REG_HOLD:    cfg_next.hold_ticks    = data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.qualify_ticks <= QUALIFY_RESET;
            cfg_reg.enter_ticks   <= ENTER_RESET;
            cfg_reg.exit_ticks    <= EXIT_RESET;
            cfg_reg.hold_ticks    <= HOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/kpdc_class.sv
// ----------------------------------------------------------------------------
// kpdc_class
// Input register, press counter, phase and class state, result generation.
// ----------------------------------------------------------------------------
module kpdc_class #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_key,
    output logic              in_ready,
    input  kpdc_pkg::cfg_t    cfg,
    input  logic              res_space,
    output logic              res_push,
    output kpdc_pkg::result_t res
);
    import kpdc_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   key_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] count_inc;
    phase_t                 phase_reg;
    phase_t                 phase_next;
    class_t                 class_reg;
    class_t                 class_next;
    class_t                 class_cur;
    logic                   event_now;
    logic                   commit;
    logic                   in_fire;
    logic [CMP_W-1:0]       cnt_ext;

    assign commit   = s1_valid_reg && res_space;
    assign in_ready = !s1_valid_reg || res_space;
    assign in_fire  = in_valid && in_ready;

    // saturating increment
    assign count_inc = (count_reg != '1) ? count_reg + 1'b1 : count_reg;
    assign cnt_ext   = CMP_W'(count_inc);

    always_comb
    begin
        count_next = count_reg;
        phase_next = phase_reg;
        class_cur  = class_reg;
        event_now  = 1'b0;
        if (!key_reg)
        begin
            // early release keeps the count
            if (phase_reg != PH_IDLE)
            begin
                event_now  = 1'b1;
                phase_next = PH_IDLE;
                count_next = '0;
            end
        end
        else
        begin
            count_next = count_inc;
            if (phase_reg == PH_IDLE && cnt_ext >= CMP_W'(cfg.qualify_ticks))
                phase_next = PH_PRESS;
            if (phase_next == PH_PRESS)
            begin
                if (cnt_ext >= CMP_W'(cfg.hold_ticks))
                begin
                    class_cur  = CL_EDIT;
                    event_now  = 1'b1;
                    phase_next = PH_HELD;
                end
                else if (cnt_ext >= CMP_W'(cfg.exit_ticks))
                    class_cur = CL_EXIT;
                else if (cnt_ext >= CMP_W'(cfg.enter_ticks))
                    class_cur = CL_ENTER;
            end
        end
        // consumer acknowledge folded in
        class_next = event_now ? CL_IDLE : class_cur;
    end

    assign s1_valid_next = in_fire || (s1_valid_reg && !commit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            count_reg    <= '0;
            phase_reg    <= PH_IDLE;
            class_reg    <= CL_IDLE;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (commit)
            begin
                count_reg <= count_next;
                phase_reg <= phase_next;
                class_reg <= class_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            key_reg <= in_key;
    end

    assign res_push       = commit;
    assign res.key_event  = event_now;
    assign res.hold_class = class_cur;
    assign res.key_phase  = phase_next;

    a_release_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !key_reg) |-> (res.key_phase == PH_IDLE))
        else $error("release did not return phase to idle");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && key_reg && count_reg != '1)
            |=> (count_reg == COUNT_WIDTH'($past(count_reg) + 1'b1)))
        else $error("press count did not advance");

    a_hold_event: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && phase_reg == PH_PRESS && phase_next == PH_HELD)
            |-> (event_now && class_cur == CL_EDIT))
        else $error("hold entry without edit event");

    a_idle_class: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && event_now) |=> (class_reg == CL_IDLE))
        else $error("class not cleared after event");

endmodule

>>> rtl/core/kpdc_out_buf.sv
// ----------------------------------------------------------------------------
// kpdc_out_buf
// Two-entry result buffer: head register plus skid register.
// ----------------------------------------------------------------------------
module kpdc_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  kpdc_pkg::result_t push_data,
    output logic              space,
    output logic              out_valid,
    input  logic              out_ready,
    output kpdc_pkg::result_t head_data
);
    import kpdc_pkg::*;

    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       pop;
    result_t    head_reg;
    result_t    skid_reg;

    assign out_valid = (fill_reg != 2'd0);
    assign space     = (fill_reg != 2'd2);
    assign pop       = out_valid && out_ready;
    assign head_data = head_reg;

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 2'd1;
        else if (!push && pop)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= 2'd0;
        else
            fill_reg <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (fill_reg == 2'd2)
                head_reg <= skid_reg;
            else if (push)
                head_reg <= push_data;
            if (push && fill_reg == 2'd2)
                skid_reg <= push_data;
        end
        else if (push)
        begin
            if (fill_reg == 2'd0)
                head_reg <= push_data;
            else
                skid_reg <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != 2'd3) && !(push && fill_reg == 2'd2))
        else $error("result buffer overflow");

endmodule

>>> rtl/core/key_press_duration_classifier.sv
// ----------------------------------------------------------------------------
// key_press_duration_classifier
// Key press qualifier and hold-time classifier, one key sample per item.
// ----------------------------------------------------------------------------
// Each input item is one sampled key level (one per debounce tick). The block
// takes one item per clock while its result buffer has space and returns
// exactly one result item per input item, in order: key_event, hold_class
// (0 idle, 1 enter, 2 exit, 3 edit) and key_phase (0 idle, 1 press accepted,
// 2 held). An accepted item is held in the input register, where the press
// counter, phase and class are updated by a saturating increment and four
// threshold compares; its result then goes to the result buffer, from which
// it is offered. The buffer holds two results, so input stays ready while
// one result waits on a stalled consumer; sustained rate is one item per
// clock while the consumer keeps up. Thresholds are written through
// cfg_we/cfg_idx/cfg_data (0 qualify, 1 enter, 2 exit, 3 hold) and must only
// be changed while no item is in flight.
// ----------------------------------------------------------------------------
module key_press_duration_classifier #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    kpdc_in_if.sink                        in_ch,
    kpdc_out_if.source                     out_ch,
    input  logic                           cfg_we,
    input  logic [kpdc_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [kpdc_pkg::CFG_W-1:0]     cfg_data
);
    import kpdc_pkg::*;

    cfg_t    cfg;
    logic    res_space;
    logic    res_push;
    result_t res;
    result_t res_head;
    logic    in_ready;

    // threshold registers
    kpdc_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .idx   (cfg_idx),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    // input register and classifier state
    kpdc_class #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_class (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_key    (in_ch.key_down),
        .in_ready  (in_ready),
        .cfg       (cfg),
        .res_space (res_space),
        .res_push  (res_push),
        .res       (res)
    );

    // result buffer decouples the consumer's ready from the input side
    kpdc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res),
        .space     (res_space),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .head_data (res_head)
    );

    assign in_ch.ready       = in_ready;
    assign out_ch.key_event  = res_head.key_event;
    assign out_ch.hold_class = res_head.hold_class;
    assign out_ch.key_phase  = res_head.key_phase;

endmodule

>>> sim/tb_key_press_duration_classifier.sv
// ----------------------------------------------------------------------------
// tb_key_press_duration_classifier
// Self-checking bench for the key press duration classifier. A short table of
// key samples covers the press qualify, the hold classes, early releases and
// odd threshold settings. It is followed by a press under maximum thresholds
// that never qualifies, then random press/release sequences under several
// threshold settings. Every result item is checked against a hand-written
// table expectation or a behavioral copy of the classifier kept in this bench.
// ----------------------------------------------------------------------------
module tb_key_press_duration_classifier;

    import kpdc_pkg::*;

    localparam int CNT_W          = 16;
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no item moving on either side
    localparam int SQUEEZE_CYCLES = 60;     // long consumer hold-off
    localparam int DRAIN_CYCLES   = 8;      // pipeline is two deep, so this is plenty
    localparam int MAX_REPORTS    = 10;

    // One row of the directed table: either a threshold load or one key sample.
    // Rows with want_known carry a hand-written expected result.
    typedef struct {
        bit      set_thr;
        cfg_t    thr;
        bit      key;
        bit      want_known;
        result_t want;
    } tick_row_t;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    kpdc_in_if  in_ch ();
    kpdc_out_if out_ch ();

    key_press_duration_classifier #(
        .COUNT_WIDTH (CNT_W)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    // Behavioral classifier state and its copy of the thresholds
    cfg_t             thr;
    logic [CNT_W-1:0] pr_count;
    phase_t           pr_phase;
    class_t           pr_class;

    result_t   pending_reports[$];   // results still owed by the block, oldest first
    tick_row_t tick_rows[$];

    bit idle_en;        // random gaps on both sides
    bit squeeze_req;    // asks the sink for one long hold-off

    int n_sent;
    int n_results;
    int n_events;
    int n_bad;
    int n_thr_loads;
    int n_squeeze;
    int class_seen[4];
    int quiet_cycles;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Behavioral classifier: one key sample in, one result out.
    // Counter saturates; release before the press is accepted leaves it alone.
    // ------------------------------------------------------------------------
    function automatic result_t classify_tick(input bit key);
        result_t r;
        logic    ev;
        ev = 1'b0;
        if (!key)
        begin
            // release: only meaningful once the press was accepted
            if (pr_phase != PH_IDLE)
            begin
                ev       = 1'b1;
                pr_phase = PH_IDLE;
                pr_count = '0;
            end
        end
        else
        begin
            if (pr_count != '1)
                pr_count = pr_count + 1'b1;
            if (pr_phase == PH_IDLE && pr_count >= thr.qualify_ticks)
                pr_phase = PH_PRESS;
            // edit is tested first, so out-of-order thresholds resolve to it
            if (pr_phase == PH_PRESS)
            begin
                if (pr_count >= thr.hold_ticks)
                begin
                    pr_class = CL_EDIT;
                    ev       = 1'b1;
                    pr_phase = PH_HELD;
                end
                else if (pr_count >= thr.exit_ticks)
                    pr_class = CL_EXIT;
                else if (pr_count >= thr.enter_ticks)
                    pr_class = CL_ENTER;
            end
        end
        r.key_event  = ev;
        r.hold_class = pr_class;
        r.key_phase  = pr_phase;
        // consumer acknowledge is folded in: class drops to idle after an event
        if (ev)
            pr_class = CL_IDLE;
        return r;
    endfunction

    function automatic cfg_t mk_thr(input int q, input int e, input int x, input int h);
        cfg_t c;
        c.qualify_ticks = q[CFG_W-1:0];
        c.enter_ticks   = e[CFG_W-1:0];
        c.exit_ticks    = x[CFG_W-1:0];
        c.hold_ticks    = h[CFG_W-1:0];
        return c;
    endfunction

    // Small random thresholds so presses reach every class in a few dozen
    // ticks; the order among them is random, so out-of-order cases show up.
    function automatic cfg_t rand_thr();
        return mk_thr($urandom_range(1, 6), $urandom_range(1, 30),
                      $urandom_range(1, 30), $urandom_range(1, 30));
    endfunction

    // ------------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------------
    function automatic void row_thr(input cfg_t c);
        tick_row_t r;
        r            = '{default: '0};
        r.set_thr    = 1'b1;
        r.thr        = c;
        tick_rows.push_back(r);
    endfunction

    function automatic void row_key(input bit key);
        tick_row_t r;
        r     = '{default: '0};
        r.key = key;
        tick_rows.push_back(r);
    endfunction

    function automatic void row_key_chk(input bit key, input bit ev, input class_t cls,
                                        input phase_t ph);
        tick_row_t r;
        r                 = '{default: '0};
        r.key             = key;
        r.want_known      = 1'b1;
        r.want.key_event  = ev;
        r.want.hold_class = cls;
        r.want.key_phase  = ph;
        tick_rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Offers one key sample, waits for the handshake, then files the expected
    // result. Called and returns at a falling edge.
    task automatic send_tick(input bit key, input bit want_known, input result_t want);
        result_t guess;
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.key_down <= key;
        do
            @(posedge clk);
        while (!in_ch.ready);
        guess = classify_tick(key);
        pending_reports.push_back(want_known ? want : guess);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic send_key(input bit key);
        send_tick(key, 1'b0, '0);
    endtask

    // Thresholds only change with nothing in flight: every item owes exactly
    // one result, so an empty expectation queue means the block is idle.
    task automatic load_thresholds(input cfg_t c);
        in_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_QUALIFY;
        cfg_data <= c.qualify_ticks;
        @(negedge clk);
        cfg_idx  <= REG_ENTER;
        cfg_data <= c.enter_ticks;
        @(negedge clk);
        cfg_idx  <= REG_EXIT;
        cfg_data <= c.exit_ticks;
        @(negedge clk);
        cfg_idx  <= REG_HOLD;
        cfg_data <= c.hold_ticks;
        @(negedge clk);
        cfg_we   <= 1'b0;
        thr = c;
        n_thr_loads++;
    endtask

    // Random phase: mostly complete presses of random length, some presses
    // cut short before acceptance, and some raw noise. With squeeze set, the
    // sink holds off once while this phase keeps offering items.
    task automatic run_press_phase(input cfg_t c, input int n_items, input bit squeeze);
        int start;
        int reach;
        int len;
        int pick;
        start = n_sent;
        load_thresholds(c);
        if (squeeze)
            squeeze_req = 1'b1;
        reach = int'(c.hold_ticks);
        if (int'(c.exit_ticks) > reach)
            reach = int'(c.exit_ticks);
        if (int'(c.enter_ticks) > reach)
            reach = int'(c.enter_ticks);
        if (int'(c.qualify_ticks) > reach)
            reach = int'(c.qualify_ticks);
        reach = reach + 3;
        if (reach > 400)
            reach = 400;
        while (n_sent - start < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                len = $urandom_range(1, reach);
                repeat (len) send_key(1'b1);
                repeat ($urandom_range(1, 3)) send_key(1'b0);
            end
            else if (pick < 90)
            begin
                // early release: with qualify above one, counter must carry over into the next press
                len = (c.qualify_ticks > 1) ? $urandom_range(1, c.qualify_ticks - 1) : 1;
                repeat (len) send_key(1'b1);
                send_key(1'b0);
            end
            else
            begin
                repeat ($urandom_range(1, 8)) send_key(1'($urandom_range(0, 1)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: consumer with random stalls and one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (squeeze_req)
            begin
                // hold off long enough for the block to fill and stall its input
                squeeze_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(negedge clk);
                n_squeeze++;
            end
            else if (idle_en && $urandom_range(0, 9) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    task automatic log_mismatch(input string what, input result_t want, input result_t got);
        n_bad++;
        if (n_bad <= MAX_REPORTS)
            $display("mismatch (%s) at result %0d: want %0d/%0d/%0d, got %0d/%0d/%0d",
                     what, n_results, want.key_event, want.hold_class, want.key_phase,
                     got.key_event, got.hold_class, got.key_phase);
    endtask

    // Check each accepted result against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.key_event  = out_ch.key_event;
            got.hold_class = class_t'(out_ch.hold_class);
            got.key_phase  = phase_t'(out_ch.key_phase);
            if (pending_reports.size() == 0)
                log_mismatch("no item pending", '0, got);
            else
            begin
                want = pending_reports.pop_front();
                if (got.key_event !== want.key_event
                    || got.hold_class !== want.hold_class
                    || got.key_phase !== want.key_phase)
                    log_mismatch("field", want, got);
            end
            n_results++;
            if (got.key_event === 1'b1)
                n_events++;
            if (!$isunknown(got.hold_class))
                class_seen[got.hold_class]++;
        end
    end

    // Watchdog: nothing moving on either channel for too long ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.key_down = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = REG_QUALIFY;
        cfg_data       = '0;
        idle_en        = 1'b1;
        squeeze_req    = 1'b0;
        quiet_cycles   = 0;

        // bench copy of the post-reset state
        thr      = mk_thr(int'(QUALIFY_RESET), int'(ENTER_RESET), int'(EXIT_RESET),
                          int'(HOLD_RESET));
        pr_count = '0;
        pr_phase = PH_IDLE;
        pr_class = CL_IDLE;

        // -- directed table --------------------------------------------------
        // Reset thresholds (qualify 5): release while idle, early release that
        // keeps the count, acceptance on the fifth pressed tick, release event.
        row_key_chk(1'b0, 1'b0, CL_IDLE, PH_IDLE);
        row_key_chk(1'b1, 1'b0, CL_IDLE, PH_IDLE);
        row_key_chk(1'b1, 1'b0, CL_IDLE, PH_IDLE);
        row_key_chk(1'b1, 1'b0, CL_IDLE, PH_IDLE);
        row_key_chk(1'b0, 1'b0, CL_IDLE, PH_IDLE);
        row_key_chk(1'b1, 1'b0, CL_IDLE, PH_IDLE);
        row_key_chk(1'b1, 1'b0, CL_IDLE, PH_PRESS);
        row_key_chk(1'b0, 1'b1, CL_IDLE, PH_IDLE);
        // tight ordered thresholds: walk every class, then hold and release
        row_thr(mk_thr(1, 2, 3, 4));
        row_key_chk(1'b1, 1'b0, CL_IDLE,  PH_PRESS);
        row_key_chk(1'b1, 1'b0, CL_ENTER, PH_PRESS);
        row_key_chk(1'b1, 1'b0, CL_EXIT,  PH_PRESS);
        row_key_chk(1'b1, 1'b1, CL_EDIT,  PH_HELD);
        row_key_chk(1'b1, 1'b0, CL_IDLE,  PH_HELD);
        row_key_chk(1'b0, 1'b1, CL_IDLE,  PH_IDLE);
        // release while classed as enter carries that class out with the event
        row_key(1'b1);
        row_key(1'b1);
        row_key_chk(1'b0, 1'b1, CL_ENTER, PH_IDLE);
        row_key(1'b0);
        // zero qualify and thresholds out of order: edit wins over exit/enter
        row_thr(mk_thr(0, 3, 1, 2));
        row_key_chk(1'b1, 1'b0, CL_EXIT, PH_PRESS);
        row_key_chk(1'b1, 1'b1, CL_EDIT, PH_HELD);
        row_key_chk(1'b0, 1'b1, CL_IDLE, PH_IDLE);
        // all thresholds at max; count left standing for the press below
        row_thr(mk_thr(65535, 65535, 65535, 65535));
        row_key(1'b1);
        row_key(1'b0);
        row_key(1'b1);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (tick_rows[i])
        begin
            if (tick_rows[i].set_thr)
                load_thresholds(tick_rows[i].thr);
            else
                send_tick(tick_rows[i].key, tick_rows[i].want_known, tick_rows[i].want);
        end

        // -- press under max thresholds: counts on, never qualifies ----------
        repeat (20) send_key(1'b1);
        repeat (2) send_key(1'b0);

        // -- random phases ---------------------------------------------------
        // long consumer stall early in the first phase
        run_press_phase(rand_thr(), 80, 1'b1);
        repeat (3) run_press_phase(rand_thr(), 80, 1'b0);
        run_press_phase(mk_thr(int'(QUALIFY_RESET), int'(ENTER_RESET), int'(EXIT_RESET),
                               int'(HOLD_RESET)), 200, 1'b0);
        run_press_phase(mk_thr(2, 4, 8, 12), 80, 1'b0);
        run_press_phase(mk_thr(1, 1, 1, 1), 50, 1'b0);

        // last stretch runs back to back on both sides
        idle_en = 1'b0;
        run_press_phase(rand_thr(), 120, 1'b0);

        // -- drain and verdict -----------------------------------------------
        in_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d key samples, %0d results, %0d events, %0d threshold loads",
                 n_sent, n_results, n_events, n_thr_loads);
        $display("classes seen idle/enter/exit/edit: %0d/%0d/%0d/%0d, long stalls: %0d",
                 class_seen[0], class_seen[1], class_seen[2], class_seen[3], n_squeeze);
        if (n_bad == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/kpdc_pkg.sv
rtl/core/kpdc_in_if.sv
rtl/core/kpdc_out_if.sv
rtl/core/kpdc_cfg.sv
rtl/core/kpdc_class.sv
rtl/core/kpdc_out_buf.sv
rtl/core/key_press_duration_classifier.sv
sim/tb_key_press_duration_classifier.sv
